// ===== src/assert_macros.svh =====
// Assertion helpers. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/ifcu_pkg.sv =====
`timescale 1ns / 1ps

package ifcu_pkg;

    localparam int POS_W  = 7;
    localparam int BYTE_W = 8;
    localparam int SUM_W  = 16;
    localparam int WORD_W = 32;
    localparam int WIDX_W = 5;

    typedef struct packed {
        logic accept;
        logic clr_k;
        logic inc_k;
        logic rd_issue;
        logic load_word;
        logic load_err;
    } ifcu_cmd_t;

    typedef struct packed {
        logic last_pos;
        logic sum_match;
        logic word_last;
    } ifcu_stat_t;

endpackage

// ===== src/ifcu_ram.sv =====
`timescale 1ns / 1ps

module ifcu_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 19,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ifcu_datapath.sv =====
`timescale 1ns / 1ps

module ifcu_datapath import ifcu_pkg::*; #(
    parameter int FRAME_BYTES = 79,
    parameter int WORD_COUNT  = 19
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ifcu_cmd_t         cmd,
    input  logic [BYTE_W-1:0] rx_byte,
    output ifcu_stat_t        stat,
    output logic [WIDX_W-1:0] word_index,
    output logic [WORD_W-1:0] word_value,
    output logic              frame_ok,
    output logic              last_word
);

    localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [POS_W-1:0]  SUM_HI_POS = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(FRAME_BYTES - 1);
    localparam logic [WIDX_W-1:0] LAST_K     = WIDX_W'(WORD_COUNT - 1);
    localparam logic [WIDX_W-1:0] WORD_LIM   = WIDX_W'(WORD_COUNT);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [WORD_W-1:0] asm_reg, asm_next;
    logic [BYTE_W-1:0] hi_reg, hi_next;
    logic [WIDX_W-1:0] k_reg, k_next;

    logic [WIDX_W-1:0] idx_reg;
    logic [WORD_W-1:0] val_reg;
    logic              ok_reg;
    logic              last_reg;

    logic [POS_W-1:0]  rel;
    logic [WIDX_W-1:0] widx;
    logic [WORD_W-1:0] asm_shift;
    logic              in_body;
    logic              we;
    logic [WORD_W-1:0] rdata;

    assign rel       = pos_reg - 1'b1;
    assign widx      = rel[POS_W-1:2];
    assign asm_shift = {asm_reg[WORD_W-BYTE_W-1:0], rx_byte};
    assign in_body   = pos_reg < SUM_HI_POS;
    assign we        = cmd.accept && in_body && (pos_reg != '0)
                       && (rel[1:0] == 2'b11) && (widx < WORD_LIM);

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        asm_next = asm_reg;
        hi_next  = hi_reg;
        if (cmd.accept)
        begin
            if (in_body)
            begin
                sum_next = sum_reg + {{(SUM_W-BYTE_W){1'b0}}, rx_byte};
                if (pos_reg != '0)
                begin
                    asm_next = asm_shift;
                end
                pos_next = pos_reg + 1'b1;
            end
            else if (pos_reg == SUM_HI_POS)
            begin
                hi_next  = rx_byte;
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                pos_next = '0;
                sum_next = '0;
                asm_next = '0;
                hi_next  = '0;
            end
        end
    end

    always_comb
    begin
        k_next = k_reg;
        if (cmd.clr_k)
        begin
            k_next = '0;
        end
        else if (cmd.inc_k)
        begin
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
            asm_reg <= '0;
            hi_reg  <= '0;
            k_reg   <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            asm_reg <= asm_next;
            hi_reg  <= hi_next;
            k_reg   <= k_next;
        end
    end

    ifcu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_COUNT)
    ) u_words (
        .clk   (clk),
        .we    (we),
        .waddr (widx[ADDR_W-1:0]),
        .wdata (asm_shift),
        .re    (cmd.rd_issue),
        .raddr (k_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_word)
        begin
            idx_reg  <= k_reg;
            val_reg  <= rdata;
            ok_reg   <= 1'b1;
            last_reg <= (k_reg == LAST_K);
        end
        else if (cmd.load_err)
        begin
            idx_reg  <= '0;
            val_reg  <= '0;
            ok_reg   <= 1'b0;
            last_reg <= 1'b1;
        end
    end

    assign stat.last_pos  = (pos_reg == LAST_POS);
    assign stat.sum_match = ({hi_reg, rx_byte} == sum_reg);
    assign stat.word_last = (k_reg == LAST_K);

    assign word_index = idx_reg;
    assign word_value = val_reg;
    assign frame_ok   = ok_reg;
    assign last_word  = last_reg;

endmodule

// ===== src/ifcu_ctrl.sv =====
`timescale 1ns / 1ps

module ifcu_ctrl import ifcu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       res_ready,
    input  ifcu_stat_t stat,
    output logic       rx_ready,
    output logic       res_valid,
    output ifcu_cmd_t  cmd
);

    localparam logic [1:0] ST_RX   = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_LD   = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       rx_acc;
    logic       res_acc;

    // last byte is held off while an earlier result still sits in the output register
    assign rx_ready = (state_reg == ST_RX)
                      && (!stat.last_pos || !out_valid_reg || res_ready);
    assign rx_acc   = rx_valid && rx_ready;
    assign res_acc  = out_valid_reg && res_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = rx_acc;
        unique case (state_reg)
            ST_RX:
            begin
                if (rx_acc && stat.last_pos)
                begin
                    if (stat.sum_match)
                    begin
                        cmd.clr_k  = 1'b1;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        cmd.load_err = 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LD;
            end
            ST_LD:
            begin
                cmd.load_word = 1'b1;
                state_next    = stat.word_last ? ST_RX : ST_WAIT;
            end
            ST_WAIT:
            begin
                if (res_acc)
                begin
                    cmd.inc_k  = 1'b1;
                    state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_RX;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_word || cmd.load_err)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_acc)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;

endmodule

// ===== src/imu_frame_checksum_unpacker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Fixed-length frame parser with a 16-bit additive checksum. Bytes are taken
// one per cycle while rx_ready is high; frame boundaries are counted from
// reset, with no resync. Every byte but the last produces no beat. On the
// last byte the received big-endian sum is checked: a mismatch loads one
// error beat at once and reception goes on; a match starts readout of the
// WORD_COUNT stored words, each by a RAM read and an output load, then, for
// all but the last word, a wait for the handoff, and rx_ready is low
// throughout. The final word stays in the output register while the next
// frame is received. The last byte of a frame is not taken until the output
// register is free.
module imu_frame_checksum_unpacker import ifcu_pkg::*; #(
    parameter int FRAME_BYTES = 79,
    parameter int WORD_COUNT  = 19
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [WIDX_W-1:0] word_index,
    output logic [WORD_W-1:0] word_value,
    output logic              frame_ok,
    output logic              last_word
);

    ifcu_cmd_t  cmd;
    ifcu_stat_t stat;

    ifcu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .res_ready (res_ready),
        .stat      (stat),
        .rx_ready  (rx_ready),
        .res_valid (res_valid),
        .cmd       (cmd)
    );

    ifcu_datapath #(
        .FRAME_BYTES (FRAME_BYTES),
        .WORD_COUNT  (WORD_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rx_byte    (rx_byte),
        .stat       (stat),
        .word_index (word_index),
        .word_value (word_value),
        .frame_ok   (frame_ok),
        .last_word  (last_word)
    );

    `ASSERT_CLK(a_load_word_empty, cmd.load_word |-> !res_valid, "word load over pending beat")
    `ASSERT_CLK(a_load_err_free, cmd.load_err |-> (!res_valid || res_ready), "error beat lost")
    `ASSERT_CLK(a_read_then_load, cmd.rd_issue |=> cmd.load_word, "read not followed by load")
    `ASSERT_ALWAYS(a_no_rx_in_readout, !(cmd.accept && (cmd.load_word || cmd.rd_issue)), "byte during readout")

endmodule
